### rtl/ubx_enc_pkg.sv
// ----------------------------------------------------------------------------
// ubx_enc_pkg
// Shared constants, the result-pair type and the hex digit decode for the
// UBX command string encoder.
// ----------------------------------------------------------------------------
package ubx_enc_pkg;

    // sync bytes sent ahead of a framed body
    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    // characters with a meaning in the command string
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // bytes produced by the line escapes
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;

    // up to two bytes produced by one character
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } res_pair_t;

    // hex digit value, anything that is not a hex digit reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_0 && c <= CH_9) begin
                d = c - CH_0;
            end else if (c >= CH_LA && c <= CH_LF) begin
                d = c - CH_LA + 8'd10;
            end else if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA + 8'd10;
            end
            hex_value = d[3:0];
        end
    endfunction

endpackage

### rtl/ubx_enc_obuf.sv
// ----------------------------------------------------------------------------
// ubx_enc_obuf
// Two-byte result register: loads the bytes caused by one character and
// hands them out one per request, marking the final one with tlast.
// ----------------------------------------------------------------------------
module ubx_enc_obuf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  ubx_enc_pkg::res_pair_t load_data,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] out_byte
    output logic                   m_tlast    // last_of_run
);
    import ubx_enc_pkg::*;

    logic [1:0] count_reg, count_next;
    logic [7:0] byte0_reg, byte0_next;
    logic [7:0] byte1_reg, byte1_next;
    logic       pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = byte0_reg;
    assign m_tlast  = (count_reg == 2'd1);

    // free when empty, or when the last byte leaves in this cycle
    assign can_load = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);

    // drain, then refill from the next character
    always_comb begin
        count_next = count_reg;
        byte0_next = byte0_reg;
        byte1_next = byte1_reg;
        if (pop) begin
            count_next = count_reg - 2'd1;
            byte0_next = byte1_reg;
        end
        if (load) begin
            count_next = load_data.count;
            byte0_next = load_data.byte0;
            byte1_next = load_data.byte1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
    end

endmodule

### rtl/ubx_frame_escape_encoder_core.sv
// ----------------------------------------------------------------------------
// ubx_frame_escape_encoder_core
// Turns the characters of a send command into transmit bytes: optional UBX
// sync and Fletcher-8 trailer, with \xHH, \n and \r escapes decoded.
// ----------------------------------------------------------------------------
//  channel | direction | tdata          | tuser / tlast
//  s_      | in        | [7:0] ch       | tuser: start_req
//  m_      | out       | [7:0] out_byte | tlast: last_of_run
//
//  Each character is decoded in the cycle it is taken; its bytes sit in the
//  result register from the next cycle, out one byte per cycle unless m_ stalls.
//  A character gives zero, one or two bytes, so with no stall on m_ the rate
//  is one character per cycle for single bytes or none; a sync or checksum
//  pair holds the next one until its second byte leaves (single result port).
//  s_tready is high while the result register is empty or its last byte is
//  being taken; a stall on m_ holds the bytes and, in turn, s_.
//  Reset clears the decoder to idle and empties the result register.
// ----------------------------------------------------------------------------
module ubx_frame_escape_encoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tuser,   // start_req
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last_of_run
);
    import ubx_enc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_HEX2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       framed_reg, framed_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;
    logic [3:0] nib_reg, nib_next;

    logic       accept;
    logic       can_load;
    res_pair_t  res;
    logic       body_put;
    logic [7:0] body_byte;
    logic [7:0] sum_a_add;

    assign s_tready = can_load;
    assign accept   = s_tvalid && s_tready;

    // decode one character
    always_comb begin
        phase_next  = phase_reg;
        framed_next = framed_reg;
        nib_next    = nib_reg;
        res         = '0;
        body_put    = 1'b0;
        body_byte   = s_tdata;
        if (s_tuser) begin
            nib_next = 4'd0;
            if (s_tdata == CH_U) begin
                framed_next = 1'b1;
                res.count   = 2'd2;
                res.byte0   = SYNC_ONE;
                res.byte1   = SYNC_TWO;
                phase_next  = PH_SKIP;
            end else begin
                framed_next = 1'b0;
                phase_next  = PH_BODY;
            end
        end else begin
            case (phase_reg)
                PH_SKIP: begin
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    if (s_tdata == CH_NUL || s_tdata == CH_QUOTE) begin
                        // trailer: checksum pair as it stood before the end
                        if (framed_reg) begin
                            res.count = 2'd2;
                            res.byte0 = sum_a_reg;
                            res.byte1 = sum_b_reg;
                        end
                        phase_next = PH_IDLE;
                    end else if (s_tdata == CH_BSL) begin
                        phase_next = PH_ESC;
                    end else begin
                        body_put = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (s_tdata == CH_X) begin
                        phase_next = PH_HEX1;
                    end else begin
                        body_put = 1'b1;
                        if (s_tdata == CH_N) begin
                            body_byte = BYTE_LF;
                        end else if (s_tdata == CH_R) begin
                            body_byte = BYTE_CR;
                        end
                        phase_next = PH_BODY;
                    end
                end
                PH_HEX1: begin
                    nib_next   = hex_value(s_tdata);
                    phase_next = PH_HEX2;
                end
                PH_HEX2: begin
                    body_put   = 1'b1;
                    body_byte  = {nib_reg, hex_value(s_tdata)};
                    phase_next = PH_BODY;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        if (body_put) begin
            res.count = 2'd1;
            res.byte0 = body_byte;
        end
    end

    // fletcher-8 running pair, cleared at each start
    assign sum_a_add = sum_a_reg + body_byte;

    always_comb begin
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        if (s_tuser) begin
            sum_a_next = 8'd0;
            sum_b_next = 8'd0;
        end else if (body_put) begin
            sum_a_next = sum_a_add;
            sum_b_next = sum_b_reg + sum_a_add;
        end
    end

    // decoder state, updated on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            framed_reg <= 1'b0;
            sum_a_reg  <= 8'd0;
            sum_b_reg  <= 8'd0;
            nib_reg    <= 4'd0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            framed_reg <= framed_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            nib_reg    <= nib_next;
        end
    end

    ubx_enc_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .load_data (res),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
